// File: rtl/core/cls_pkg.sv
// Shared types, constants and helper functions of the C line lexical scanner.
package cls_pkg;

    localparam int MAX_LINE_LEN = 1023;
    localparam int POS_CAP      = (MAX_LINE_LEN < 1023) ? MAX_LINE_LEN : 1023;
    localparam int POS_W        = 10;
    localparam int DELTA_W      = 11;
    localparam int DELTA_MAX    = 1023;
    localparam int TAG_LEN      = 7;
    localparam int PROG_W       = 3;

    localparam logic [0:0] KIND_CHAR = 1'b0;
    localparam logic [0:0] KIND_EOL  = 1'b1;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef struct packed {
        logic                      in_block;
        logic                      in_string;
        logic                      in_charlit;
        logic                      escape_pending;
        logic                      slash_pending;
        logic                      star_pending;
        logic                      in_line_comment;
        logic signed [DELTA_W-1:0] running_delta;
        logic                      code_seen;
        logic                      first_nonspace_seen;
        logic                      first_is_hash;
        logic [PROG_W-1:0]         match_progress;
        logic                      tag_seen;
        logic [POS_W-1:0]          tag_position;
        logic [POS_W-1:0]          char_position;
    } line_state_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] brace_delta;
        logic                      code_line;
        logic                      tag_found;
        logic [POS_W-1:0]          tag_offset;
        logic                      block_open;
    } line_result_t;

    function automatic logic [7:0] tag_char(input logic [PROG_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h40; // @
            3'd1:    c = 8'h63; // c
            3'd2:    c = 8'h61; // a
            3'd3:    c = 8'h6D; // m
            3'd4:    c = 8'h65; // e
            3'd5:    c = 8'h72; // r
            3'd6:    c = 8'h61; // a
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

endpackage

// File: rtl/core/cls_if.sv
// Valid/ready channel interfaces for character requests and line results.
interface cls_item_if;
    logic       valid;
    logic       ready;
    logic [0:0] kind;
    logic [7:0] ch;

    modport source (output valid, output kind, output ch, input ready);
    modport sink   (input valid, input kind, input ch, output ready);
endinterface

interface cls_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [cls_pkg::DELTA_W-1:0] brace_delta;
    logic                               code_line;
    logic                               tag_found;
    logic [cls_pkg::POS_W-1:0]          tag_offset;
    logic                               block_open;

    modport source (output valid, output brace_delta, output code_line, output tag_found,
                    output tag_offset, output block_open, input ready);
    modport sink   (input valid, input brace_delta, input code_line, input tag_found,
                    input tag_offset, input block_open, output ready);
endinterface

// File: rtl/core/cls_char_step.sv
// Next-state logic of the scanner for one character or end-of-line request.
module cls_char_step (
    input  cls_pkg::line_state_t  state,
    input  logic [0:0]            kind,
    input  logic [7:0]            ch,
    output cls_pkg::line_state_t  state_next,
    output cls_pkg::line_result_t result
);

    // Tag matcher: advances on the expected letter, restarts on '@'.
    function automatic cls_pkg::line_state_t match_step(input cls_pkg::line_state_t s,
                                                        input logic [7:0] c);
        cls_pkg::line_state_t r;
        logic [cls_pkg::POS_W:0] pos_inc;
        r = s;
        pos_inc = {1'b0, s.char_position} + {{cls_pkg::POS_W{1'b0}}, 1'b1};
        if (!s.tag_seen) begin
            if (c == cls_pkg::tag_char(s.match_progress)) begin
                if (s.match_progress == cls_pkg::PROG_W'(cls_pkg::TAG_LEN - 1)) begin
                    r.tag_seen = 1'b1;
                    r.match_progress = '0;
                    if (pos_inc > (cls_pkg::POS_W + 1)'(cls_pkg::POS_CAP))
                        r.tag_position = cls_pkg::POS_W'(cls_pkg::POS_CAP);
                    else
                        r.tag_position = pos_inc[cls_pkg::POS_W-1:0];
                end
                else begin
                    r.match_progress = s.match_progress + 1'b1;
                end
            end
            else begin
                r.match_progress = (c == cls_pkg::CH_AT) ? cls_pkg::PROG_W'(1) : '0;
            end
        end
        return r;
    endfunction

    // Ordinary code character: literal openers, braces and code detection.
    function automatic cls_pkg::line_state_t code_step(input cls_pkg::line_state_t s,
                                                       input logic [7:0] c);
        cls_pkg::line_state_t r;
        r = s;
        priority if (c == cls_pkg::CH_SLASH) begin
            r.slash_pending = 1'b1;
        end
        else if (c == cls_pkg::CH_DQUOTE) begin
            r.in_string = 1'b1;
            r.code_seen = 1'b1;
        end
        else if (c == cls_pkg::CH_SQUOTE) begin
            r.in_charlit = 1'b1;
            r.code_seen = 1'b1;
        end
        else begin
            if (c == cls_pkg::CH_LBRACE &&
                s.running_delta < cls_pkg::DELTA_W'(cls_pkg::DELTA_MAX))
                r.running_delta = s.running_delta + 1'b1;
            else if (c == cls_pkg::CH_RBRACE &&
                     s.running_delta > -cls_pkg::DELTA_W'(cls_pkg::DELTA_MAX))
                r.running_delta = s.running_delta - 1'b1;
            if (!cls_pkg::is_space(c))
                r.code_seen = 1'b1;
        end
        return r;
    endfunction

    cls_pkg::line_state_t s1;

    always_comb
    begin
        result.brace_delta = state.running_delta;
        result.code_line   = (state.code_seen || state.slash_pending) &&
                             !(state.first_nonspace_seen && state.first_is_hash);
        result.tag_found   = state.tag_seen;
        result.tag_offset  = state.tag_seen ? state.tag_position : '0;
        result.block_open  = state.in_block;
    end

    always_comb
    begin
        s1 = state;
        if (!state.first_nonspace_seen && !cls_pkg::is_space(ch)) begin
            s1.first_nonspace_seen = 1'b1;
            s1.first_is_hash = (ch == cls_pkg::CH_HASH);
        end

        if (kind == cls_pkg::KIND_EOL) begin
            // Everything but the block comment flag starts over on a new line.
            state_next = '0;
            state_next.in_block = state.in_block;
        end
        else begin
            state_next = s1;
            priority if (s1.in_line_comment) begin
                state_next = match_step(s1, ch);
            end
            else if (s1.in_block) begin
                if (s1.star_pending && ch == cls_pkg::CH_SLASH) begin
                    state_next.in_block = 1'b0;
                    state_next.star_pending = 1'b0;
                    state_next.match_progress = '0;
                end
                else begin
                    state_next = match_step(s1, ch);
                    state_next.star_pending = (ch == cls_pkg::CH_STAR);
                end
            end
            else if (s1.in_string || s1.in_charlit) begin
                priority if (s1.escape_pending) begin
                    state_next.escape_pending = 1'b0;
                end
                else if (ch == cls_pkg::CH_BSLASH) begin
                    state_next.escape_pending = 1'b1;
                end
                else begin
                    if (s1.in_string && ch == cls_pkg::CH_DQUOTE)
                        state_next.in_string = 1'b0;
                    if (s1.in_charlit && ch == cls_pkg::CH_SQUOTE)
                        state_next.in_charlit = 1'b0;
                end
            end
            else if (s1.slash_pending) begin
                state_next.slash_pending = 1'b0;
                priority if (ch == cls_pkg::CH_SLASH) begin
                    state_next.in_line_comment = 1'b1;
                    state_next.match_progress = '0;
                end
                else if (ch == cls_pkg::CH_STAR) begin
                    state_next.in_block = 1'b1;
                    state_next.star_pending = 1'b0;
                    state_next.match_progress = '0;
                end
                else begin
                    // The held slash was a division operator.
                    state_next.code_seen = 1'b1;
                    state_next = code_step(state_next, ch);
                end
            end
            else begin
                state_next = code_step(s1, ch);
            end

            if (state.char_position < cls_pkg::POS_W'(cls_pkg::POS_CAP))
                state_next.char_position = state.char_position + 1'b1;
        end
    end

endmodule

// File: rtl/core/c_line_lexical_scanner.sv
// An end-of-line request passes from the input register into the result register; it moves on
// once no result is waiting or the waiting one is taken.
// Throughput: one request per cycle; the input stalls only while an end of line sits in
// the input register and the previous result has not been taken yet.
// Reset (rst_n low, asynchronous) clears the line state, the block comment flag
// and both valid flags; the input is ready once reset is released.
module c_line_lexical_scanner (
    input  logic                 clk,
    input  logic                 rst_n,
    cls_item_if.sink             item,
    cls_result_if.source         result
);

    logic                  stage_valid_reg;
    logic [0:0]            stage_kind_reg;
    logic [7:0]            stage_ch_reg;
    cls_pkg::line_state_t  line_reg;
    cls_pkg::line_state_t  line_next;
    cls_pkg::line_result_t line_result;
    cls_pkg::line_result_t result_reg;
    logic                  result_valid_reg;
    logic                  stage_is_eol;
    logic                  stage_advance;

    cls_char_step u_step (
        .state      (line_reg),
        .kind       (stage_kind_reg),
        .ch         (stage_ch_reg),
        .state_next (line_next),
        .result     (line_result)
    );

    assign stage_is_eol  = stage_valid_reg && (stage_kind_reg == cls_pkg::KIND_EOL);
    assign stage_advance = stage_valid_reg &&
                           (!stage_is_eol || !result_valid_reg || result.ready);
    assign item.ready    = !stage_valid_reg || stage_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
        end
        else if (item.ready) begin
            stage_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid) begin
            stage_kind_reg <= item.kind;
            stage_ch_reg   <= item.ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_reg <= '0;
        end
        else if (stage_advance) begin
            line_reg <= line_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
        end
        else if (stage_advance && stage_is_eol) begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready) begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_advance && stage_is_eol) begin
            result_reg <= line_result;
        end
    end

    assign result.valid       = result_valid_reg;
    assign result.brace_delta = result_reg.brace_delta;
    assign result.code_line   = result_reg.code_line;
    assign result.tag_found   = result_reg.tag_found;
    assign result.tag_offset  = result_reg.tag_offset;
    assign result.block_open  = result_reg.block_open;

endmodule

// File: rtl/core/cls_checker.sv
// Port-level checks of the scanner, attached to the top level by bind.
module cls_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [cls_pkg::DELTA_W-1:0] out_brace_delta,
    input logic                               out_tag_found,
    input logic [cls_pkg::POS_W-1:0]          out_tag_offset
);

    // A result that is not taken stays on the port unchanged.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_brace_delta) &&
        $stable(out_tag_offset) && $stable(out_tag_found))
        else $error("stalled result changed");

    // Without a tag the offset reads zero.
    a_no_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_tag_found |-> out_tag_offset == '0)
        else $error("tag offset set without a tag");

    // A tag ends no earlier than just past its seventh character.
    a_tag_offset_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_tag_found |-> out_tag_offset >= cls_pkg::POS_W'(cls_pkg::TAG_LEN))
        else $error("tag offset below tag length");

    // The saturating brace count never reaches the most negative code.
    a_delta_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_brace_delta != {1'b1, {(cls_pkg::DELTA_W-1){1'b0}}})
        else $error("brace delta out of range");

    // With no result waiting, the input always takes a request.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result waiting");

endmodule

bind c_line_lexical_scanner cls_checker u_cls_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (item.ready),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .out_brace_delta (result.brace_delta),
    .out_tag_found   (result.tag_found),
    .out_tag_offset  (result.tag_offset)
);

// File: sim/tb.sv
// Self-checking testbench for the C line lexical scanner.
`timescale 1ns / 1ps

module tb;

    // Tracks the scanner state character by character and keeps the line results still owed.
    class line_scoreboard;
        bit in_block;
        bit in_string;
        bit in_charlit;
        bit escape_pending;
        bit slash_pending;
        bit star_pending;
        bit in_line_comment;
        int delta;
        bit code_seen;
        bit first_seen;
        bit first_hash;
        int match_len;
        bit tag_seen;
        int tag_pos;
        int col;
        string tag_word;
        cls_pkg::line_result_t lines_due[$];
        int errors;
        int printed;
        int lines_checked;
        int code_lines;
        int tag_lines;
        int open_lines;

        function new();
            tag_word = "@camera";
            in_block = 1'b0;
            clear_line();
        endfunction

        function bit blank(logic [7:0] c);
            return (c == cls_pkg::CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function void clear_line();
            in_string = 1'b0;
            in_charlit = 1'b0;
            escape_pending = 1'b0;
            slash_pending = 1'b0;
            star_pending = 1'b0;
            in_line_comment = 1'b0;
            delta = 0;
            code_seen = 1'b0;
            first_seen = 1'b0;
            first_hash = 1'b0;
            match_len = 0;
            tag_seen = 1'b0;
            tag_pos = 0;
            col = 0;
        endfunction

        function void match_tag(logic [7:0] c, int pos);
            if (tag_seen)
                return;
            if (match_len < cls_pkg::TAG_LEN && c == tag_word[match_len]) begin
                match_len++;
                if (match_len == cls_pkg::TAG_LEN) begin
                    tag_seen = 1'b1;
                    tag_pos = (pos + 1 > cls_pkg::POS_CAP) ? cls_pkg::POS_CAP : pos + 1;
                    match_len = 0;
                end
            end
            else begin
                match_len = (c == cls_pkg::CH_AT) ? 1 : 0;
            end
        endfunction

        function void code_char(logic [7:0] c);
            if (c == cls_pkg::CH_SLASH) begin
                slash_pending = 1'b1;
                return;
            end
            if (c == cls_pkg::CH_DQUOTE) begin
                in_string = 1'b1;
                code_seen = 1'b1;
                return;
            end
            if (c == cls_pkg::CH_SQUOTE) begin
                in_charlit = 1'b1;
                code_seen = 1'b1;
                return;
            end
            if (c == cls_pkg::CH_LBRACE && delta < cls_pkg::DELTA_MAX)
                delta++;
            else if (c == cls_pkg::CH_RBRACE && delta > -cls_pkg::DELTA_MAX)
                delta--;
            if (!blank(c))
                code_seen = 1'b1;
        endfunction

        function void note_request(logic [0:0] kind, logic [7:0] c);
            cls_pkg::line_result_t r;
            int pos;
            pos = col;
            if (kind == cls_pkg::KIND_EOL) begin
                // A slash still waiting for its partner at line end is plain code.
                if (slash_pending)
                    code_seen = 1'b1;
                r.brace_delta = delta[cls_pkg::DELTA_W-1:0];
                r.code_line = code_seen && !(first_seen && first_hash);
                r.tag_found = tag_seen;
                r.tag_offset = tag_seen ? tag_pos[cls_pkg::POS_W-1:0] : '0;
                r.block_open = in_block;
                lines_due.push_back(r);
                code_lines += int'(r.code_line);
                tag_lines += int'(r.tag_found);
                open_lines += int'(r.block_open);
                clear_line();
                return;
            end
            if (!first_seen && !blank(c)) begin
                first_seen = 1'b1;
                first_hash = (c == cls_pkg::CH_HASH);
            end
            if (in_line_comment) begin
                match_tag(c, pos);
            end
            else if (in_block) begin
                if (star_pending && c == cls_pkg::CH_SLASH) begin
                    in_block = 1'b0;
                    star_pending = 1'b0;
                    match_len = 0;
                end
                else begin
                    match_tag(c, pos);
                    star_pending = (c == cls_pkg::CH_STAR);
                end
            end
            else if (in_string || in_charlit) begin
                if (escape_pending)
                    escape_pending = 1'b0;
                else if (c == cls_pkg::CH_BSLASH)
                    escape_pending = 1'b1;
                else begin
                    if (in_string && c == cls_pkg::CH_DQUOTE)
                        in_string = 1'b0;
                    if (in_charlit && c == cls_pkg::CH_SQUOTE)
                        in_charlit = 1'b0;
                end
            end
            else if (slash_pending) begin
                slash_pending = 1'b0;
                if (c == cls_pkg::CH_SLASH) begin
                    in_line_comment = 1'b1;
                    match_len = 0;
                end
                else if (c == cls_pkg::CH_STAR) begin
                    in_block = 1'b1;
                    star_pending = 1'b0;
                    match_len = 0;
                end
                else begin
                    code_seen = 1'b1;
                    code_char(c);
                end
            end
            else begin
                code_char(c);
            end
            if (col < cls_pkg::POS_CAP)
                col++;
        endfunction

        task report(string what, int got, int want);
            errors++;
            if (printed < 200) begin
                printed++;
                $display("MISMATCH line %0d: %s got %0d, expected %0d",
                         lines_checked, what, got, want);
            end
        endtask

        task check_result(cls_pkg::line_result_t got);
            cls_pkg::line_result_t want;
            if (lines_due.size() == 0) begin
                report("result with no line outstanding", int'(got.brace_delta), 0);
                return;
            end
            want = lines_due.pop_front();
            lines_checked++;
            if (got.brace_delta !== want.brace_delta)
                report("brace_delta", int'(got.brace_delta), int'(want.brace_delta));
            if (got.code_line !== want.code_line)
                report("code_line", int'(got.code_line), int'(want.code_line));
            if (got.tag_found !== want.tag_found)
                report("tag_found", int'(got.tag_found), int'(want.tag_found));
            if (got.tag_offset !== want.tag_offset)
                report("tag_offset", int'(got.tag_offset), int'(want.tag_offset));
            if (got.block_open !== want.block_open)
                report("block_open", int'(got.block_open), int'(want.block_open));
        endtask
    endclass

    localparam int IDLE_LIMIT  = 2000;
    localparam int TOTAL_ITEMS = 1600;

    logic clk;
    logic rst_n;

    cls_item_if   item_ch();
    cls_result_if result_ch();

    c_line_lexical_scanner dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    line_scoreboard sb;
    logic [7:0] line_buf[$];
    bit line_burst;
    int items_sent;
    bit brace_run_done;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] pick_letter();
        return 8'(8'h61 + $urandom_range(0, 25));
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic void add_comment_body();
        int n;
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: line_buf.push_back(pick_letter());
                1: add_text("@camera");
                2: add_text("@cam");
                3: line_buf.push_back(cls_pkg::CH_STAR);
                4: line_buf.push_back(cls_pkg::CH_AT);
                default: line_buf.push_back(cls_pkg::CH_SPACE);
            endcase
        end
    endfunction

    function automatic void add_literal(logic [7:0] quote);
        int n;
        line_buf.push_back(quote);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: line_buf.push_back(pick_letter());
                1: line_buf.push_back(cls_pkg::CH_BSLASH);
                2: line_buf.push_back(cls_pkg::CH_SLASH);
                3: line_buf.push_back(cls_pkg::CH_STAR);
                4: line_buf.push_back(cls_pkg::CH_LBRACE);
                default: line_buf.push_back(quote);
            endcase
        end
        if ($urandom_range(0, 3) != 0)
            line_buf.push_back(quote);
    endfunction

    function automatic void add_piece();
        int n;
        case ($urandom_range(0, 13))
            0: begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    line_buf.push_back(pick_letter());
            end
            1: line_buf.push_back(cls_pkg::CH_LBRACE);
            2: line_buf.push_back(cls_pkg::CH_RBRACE);
            3: line_buf.push_back(($urandom_range(0, 1) == 0) ? cls_pkg::CH_SPACE
                                  : 8'($urandom_range(9, 13)));
            4: add_literal(cls_pkg::CH_DQUOTE);
            5: add_literal(cls_pkg::CH_SQUOTE);
            6: begin
                add_text("//");
                add_comment_body();
            end
            7: begin
                add_text("/*");
                add_comment_body();
                if ($urandom_range(0, 3) != 0)
                    add_text("*/");
            end
            8: add_text("*/");
            9: line_buf.push_back(cls_pkg::CH_SLASH);
            10: line_buf.push_back(cls_pkg::CH_STAR);
            11: line_buf.push_back(8'($urandom_range(0, 255)));
            12: add_text("@camera");
            default: line_buf.push_back(cls_pkg::CH_HASH);
        endcase
    endfunction

    function automatic void build_line();
        int n;
        line_buf.delete();
        if ($urandom_range(0, 5) == 0) begin
            n = $urandom_range(0, 2);
            for (int i = 0; i < n; i++)
                line_buf.push_back(cls_pkg::CH_SPACE);
            line_buf.push_back(cls_pkg::CH_HASH);
        end
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++)
            add_piece();
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input logic [0:0] k, input logic [7:0] c);
        int gap;
        gap = line_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.kind <= k;
        item_ch.ch <= c;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sb.note_request(k, c);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_line();
        line_burst = ($urandom_range(0, 3) == 0);
        foreach (line_buf[i])
            send_request(cls_pkg::KIND_CHAR, line_buf[i]);
        send_request(cls_pkg::KIND_EOL, 8'($urandom_range(0, 255)));
        line_buf.delete();
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.lines_due.size() != 0);
    endtask

    // Over a thousand identical braces, so both the delta and the column saturate.
    task automatic send_brace_run(input logic [7:0] brace);
        line_buf.delete();
        // Closes any block comment left open by earlier lines.
        add_text("*/");
        for (int i = 0; i < 1030; i++)
            line_buf.push_back(brace);
        if (brace == cls_pkg::CH_LBRACE)
            add_text("//@camera");
        send_line();
    endtask

    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.kind = cls_pkg::KIND_CHAR;
        item_ch.ch = 8'h00;
        rst_n = 1'b0;
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directive with a brace, a tag inside a block comment left open with a trailing
        // star, a close followed by an escape at line end, and a slash left pending.
        add_text("#{");
        line_buf.push_back(8'hFF);
        send_line();
        add_text("/*@camera*");
        send_line();
        add_text("/x*/'\\");
        send_line();
        line_buf.push_back(8'h00);
        add_text("/");
        send_line();
        drain();

        brace_run_done = 1'b0;
        while (items_sent < TOTAL_ITEMS) begin
            if (!brace_run_done && items_sent >= 300) begin
                send_brace_run(cls_pkg::CH_LBRACE);
                brace_run_done = 1'b1;
            end
            build_line();
            send_line();
            if ($urandom_range(0, 40) == 0)
                drain();
        end

        drain();
        repeat (10) @(negedge clk);
        $display("Summary: %0d requests, %0d lines checked; %0d held code, %0d carried the tag,",
                 items_sent, sb.lines_checked, sb.code_lines, sb.tag_lines);
        $display("  %0d ended in an open block comment; one long brace run saturated the counters.",
                 sb.open_lines);
        if (sb.errors == 0)
            $display("c_line_lexical_scanner verification clean");
        else
            $display("c_line_lexical_scanner verification failed");
        $finish;
    end

    initial
    begin
        int stall;
        bit burst;
        cls_pkg::line_result_t got;
        burst = 1'b0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if ($urandom_range(0, 15) == 0)
                burst = !burst;
            stall = burst ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            got.brace_delta = result_ch.brace_delta;
            got.code_line = result_ch.code_line;
            got.tag_found = result_ch.tag_found;
            got.tag_offset = result_ch.tag_offset;
            got.block_open = result_ch.block_open;
            sb.check_result(got);
            @(negedge clk);
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
                $display("c_line_lexical_scanner verification failed");
                $finish;
            end
        end
    end

endmodule
